### hdl/fwsp_pkg.sv
`timescale 1ns / 1ps

package fwsp_pkg;

  localparam int ByteWidth = 8;
  localparam int WordWidth = 16;
  localparam int PhaseWidth = 3;
  localparam int SyncRunWidth = 2;
  localparam int OutDataWidth = 2 * WordWidth;
  localparam int OutUserWidth = 2;

  localparam logic [PhaseWidth-1:0] PH_WAIT    = 3'd0;
  localparam logic [PhaseWidth-1:0] PH_ADDR_LO = 3'd1;
  localparam logic [PhaseWidth-1:0] PH_ADDR_HI = 3'd2;
  localparam logic [PhaseWidth-1:0] PH_CNT_LO  = 3'd3;
  localparam logic [PhaseWidth-1:0] PH_CNT_HI  = 3'd4;
  localparam logic [PhaseWidth-1:0] PH_DATA_LO = 3'd5;
  localparam logic [PhaseWidth-1:0] PH_DATA_HI = 3'd6;

  localparam logic [ByteWidth-1:0] SYNC_BYTE = 8'h55;
  localparam logic [WordWidth-1:0] END_ADDRESS = 16'h5555;
  localparam logic [SyncRunWidth-1:0] SYNC_LAST = 2'd3;
  localparam logic [WordWidth-1:0] WORD_BYTES = 16'd2;

  typedef struct packed {
    logic                 has_result;
    logic                 word_valid;
    logic [WordWidth-1:0] word_address;
    logic [WordWidth-1:0] word_value;
    logic                 frame_sync;
  } fwsp_result_t;

endpackage

### hdl/fwsp_parse_core.sv
`timescale 1ns / 1ps

module fwsp_parse_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [fwsp_pkg::ByteWidth-1:0]   rx_byte,
  output fwsp_pkg::fwsp_result_t           result
);

  logic [fwsp_pkg::PhaseWidth-1:0]   parse_phase;
  logic [fwsp_pkg::PhaseWidth-1:0]   parse_phase_next;
  logic [fwsp_pkg::WordWidth-1:0]    block_address;
  logic [fwsp_pkg::WordWidth-1:0]    block_address_next;
  logic [fwsp_pkg::WordWidth-1:0]    bytes_left;
  logic [fwsp_pkg::WordWidth-1:0]    bytes_left_next;
  logic [fwsp_pkg::ByteWidth-1:0]    low_data_byte;
  logic [fwsp_pkg::ByteWidth-1:0]    low_data_byte_next;
  logic [fwsp_pkg::SyncRunWidth-1:0] sync_run;
  logic [fwsp_pkg::SyncRunWidth-1:0] sync_run_next;
  logic [fwsp_pkg::WordWidth-1:0]    bytes_dec;
  logic [fwsp_pkg::WordWidth-1:0]    addr_full;
  logic                              got_word;
  logic                              got_sync;

  assign bytes_dec = bytes_left - fwsp_pkg::WordWidth'(1);
  assign addr_full = {rx_byte, block_address[fwsp_pkg::ByteWidth-1:0]};

  always_comb begin
    parse_phase_next = parse_phase;
    block_address_next = block_address;
    bytes_left_next = bytes_left;
    low_data_byte_next = low_data_byte;
    sync_run_next = sync_run;
    got_word = 1'b0;
    got_sync = 1'b0;
    unique case (parse_phase)
      fwsp_pkg::PH_ADDR_LO: begin
        block_address_next = {{fwsp_pkg::ByteWidth{1'b0}}, rx_byte};
        parse_phase_next = fwsp_pkg::PH_ADDR_HI;
      end
      fwsp_pkg::PH_ADDR_HI: begin
        block_address_next = addr_full;
        parse_phase_next = (addr_full != fwsp_pkg::END_ADDRESS) ?
                           fwsp_pkg::PH_CNT_LO : fwsp_pkg::PH_WAIT;
      end
      fwsp_pkg::PH_CNT_LO: begin
        bytes_left_next = {{fwsp_pkg::ByteWidth{1'b0}}, rx_byte};
        parse_phase_next = fwsp_pkg::PH_CNT_HI;
      end
      fwsp_pkg::PH_CNT_HI: begin
        bytes_left_next = {rx_byte, bytes_left[fwsp_pkg::ByteWidth-1:0]};
        parse_phase_next = fwsp_pkg::PH_DATA_LO;
      end
      fwsp_pkg::PH_DATA_LO: begin
        low_data_byte_next = rx_byte;
        bytes_left_next = bytes_dec;
        parse_phase_next = fwsp_pkg::PH_DATA_HI;
      end
      fwsp_pkg::PH_DATA_HI: begin
        got_word = 1'b1;
        bytes_left_next = bytes_dec;
        block_address_next = block_address + fwsp_pkg::WORD_BYTES;
        parse_phase_next = (bytes_dec == '0) ? fwsp_pkg::PH_ADDR_LO : fwsp_pkg::PH_DATA_LO;
      end
      default: begin
        parse_phase_next = fwsp_pkg::PH_WAIT;
      end
    endcase
    if (rx_byte == fwsp_pkg::SYNC_BYTE) begin
      if (sync_run == fwsp_pkg::SYNC_LAST) begin
        sync_run_next = '0;
        parse_phase_next = fwsp_pkg::PH_ADDR_LO;
        got_sync = 1'b1;
      end else begin
        sync_run_next = sync_run + fwsp_pkg::SyncRunWidth'(1);
      end
    end else begin
      sync_run_next = '0;
    end
  end

  always_comb begin
    result.has_result = got_word | got_sync;
    result.word_valid = got_word;
    result.word_address = got_word ? block_address : '0;
    result.word_value = got_word ? {rx_byte, low_data_byte} : '0;
    result.frame_sync = got_sync;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= fwsp_pkg::PH_WAIT;
      sync_run <= '0;
    end else if (step) begin
      parse_phase <= parse_phase_next;
      sync_run <= sync_run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      block_address <= block_address_next;
      bytes_left <= bytes_left_next;
      low_data_byte <= low_data_byte_next;
    end
  end

endmodule

### hdl/framed_word_stream_parser_unit.sv
`timescale 1ns / 1ps

// framed word stream parser: takes one received byte per cycle unless the output stalls,
// and reports each completed 16-bit data word with its address, and each run of four 0x55
// bytes as frame sync. a byte is held in the input register while the phase machine in the
// parse core decodes it, and its result (if any) is registered in the output register.
// bytes that complete nothing produce no output item. back pressure on the output stalls the
// input register only while a result is waiting and the next byte is ready to be decoded.

module framed_word_stream_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [fwsp_pkg::ByteWidth-1:0]      s_tdata,   // rx_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fwsp_pkg::OutDataWidth-1:0]   m_tdata,   // word_address, word_value
  output logic [fwsp_pkg::OutUserWidth-1:0]   m_tuser    // word_valid, frame_sync
);

  logic                           in_valid;
  logic [fwsp_pkg::ByteWidth-1:0] in_byte;
  logic                           proc;
  fwsp_pkg::fwsp_result_t         result;

  assign proc = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | proc;

  fwsp_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (proc),
    .rx_byte (in_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc && result.has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && result.has_result) begin
      m_tdata <= {result.word_value, result.word_address};
      m_tuser <= {result.frame_sync, result.word_valid};
    end
  end

endmodule

### hdl/fwsp_checker.sv
`timescale 1ns / 1ps

module fwsp_protocol_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [fwsp_pkg::OutDataWidth-1:0] m_tdata,
  input logic [fwsp_pkg::OutUserWidth-1:0] m_tuser
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  // every item carries a word or a sync
  a_flag_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != '0)
    else $error("output item without word or sync");

  // sync only items carry zero word fields
  a_sync_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("sync item with nonzero word fields");

  // a result needs an accepted byte; none appears out of reset before one
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || ($past(rst, 2) && !$past(s_tvalid && s_tready)) |-> !m_tvalid)
    else $error("output item without an accepted byte");

endmodule

bind framed_word_stream_parser_unit fwsp_protocol_checker u_fwsp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
